// ===== hdl/omq_pkg.sv =====
`timescale 1ns / 1ps
// omq_pkg: command and status codes and fixed field widths of the ordered match queue.
// No dependencies.
package omq_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned LVL_W   = 8;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned QCNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 3'd0,
    CMD_DEQUEUE  = 3'd1,
    CMD_PEEK     = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_FIND_OPP = 3'd4,
    CMD_REMOVE   = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

endpackage

// ===== hdl/ordered_match_queue.sv =====
`timescale 1ns / 1ps
// ordered_match_queue: arrival-ordered queue with associative search and compaction.
// Depends on omq_pkg and omq_ram.
//
// Usage:
//  - A command transfer happens at a rising edge with start high and busy low.
//    command_i selects enqueue, dequeue, peek, contains, find opponent or remove;
//    user_key_i and level_i carry the operands.
//  - Every command gives exactly one result: done_o is high for one cycle with
//    status_o, found_o, result_key_o and queue_count_o. The receiver cannot stall;
//    the result is taken at the edge that ends the done_o cycle.
//  - Entries live in one RAM (key and level per word) used as a ring: head_q marks
//    the oldest entry, count_q the fill. Read data is registered, so it arrives in the
//    cycle after the address and the scan checks one entry per cycle.
//  - Enqueue and any command on an empty queue answer straight from idle; dequeue
//    and peek read the oldest entry first; contains / find opponent walk the entries
//    until a hit or the end; remove walks to the match and then moves each younger
//    entry down one slot (one read and one write per cycle). busy stays high until
//    the result is issued; the next command may be taken in the cycle done_o is
//    high.
//  - Reset empties the queue (head and fill cleared); RAM contents are left as is
//    and never read before written.
module ordered_match_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned LEVEL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [omq_pkg::CMD_W-1:0]     command_i,
  input  logic [omq_pkg::KEY_W-1:0]     user_key_i,
  input  logic [omq_pkg::LVL_W-1:0]     level_i,
  output logic                          done_o,
  output logic [omq_pkg::STAT_W-1:0]    status_o,
  output logic                          found_o,
  output logic [omq_pkg::KEY_W-1:0]     result_key_o,
  output logic [omq_pkg::QCNT_W-1:0]    queue_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);       // slot address
  localparam int unsigned PW = AW + 1;              // ring sums before wrap
  localparam int unsigned CW = $clog2(DEPTH + 1);   // fill count 0..DEPTH
  localparam int unsigned EW = omq_pkg::KEY_W + LEVEL_BITS;

  // FSM codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;  // check one entry per cycle
  localparam logic [1:0] S_SHIFT = 2'd2;  // close the gap after a remove

  // ring wrap: input is known to stay below 2*DEPTH
  function automatic logic [AW-1:0] wrap(input logic [PW-1:0] a);
    logic [PW-1:0] r;
    begin
      r = (a >= PW'(DEPTH)) ? (a - PW'(DEPTH)) : a;
      wrap = r[AW-1:0];
    end
  endfunction

  logic [1:0]                       state_q, state_d;
  logic [AW-1:0]                    head_q, head_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [AW-1:0]                    idx_q, idx_d;
  logic [omq_pkg::CMD_W-1:0]        cmd_q, cmd_d;
  logic [omq_pkg::KEY_W-1:0]        key_q, key_d;
  logic [LEVEL_BITS-1:0]            lvl_q, lvl_d;
  logic                             done_q, done_d;
  logic [omq_pkg::STAT_W-1:0]       status_q, status_d;
  logic                             found_q, found_d;
  logic [omq_pkg::KEY_W-1:0]        rkey_q, rkey_d;
  logic [omq_pkg::QCNT_W-1:0]       qcnt_q, qcnt_d;

  // RAM port signals
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [EW-1:0]                    ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [EW-1:0]                    ram_rdata;

  logic [LEVEL_BITS-1:0]            lvl_in;
  logic [omq_pkg::KEY_W-1:0]        rd_key;
  logic [LEVEL_BITS-1:0]            rd_lvl;
  logic [PW-1:0]                    pos1, pos2;
  logic                             last1, last2, hit;
  logic [CW-1:0]                    count_dec;

  assign lvl_in    = LEVEL_BITS'(level_i);
  assign rd_key    = ram_rdata[EW-1:LEVEL_BITS];
  assign rd_lvl    = ram_rdata[LEVEL_BITS-1:0];
  assign pos1      = {1'b0, idx_q} + PW'(1);
  assign pos2      = {1'b0, idx_q} + PW'(2);
  assign last1     = (pos1 == PW'(count_q));
  assign last2     = (pos2 == PW'(count_q));
  assign count_dec = count_q - CW'(1);

  // entry test for the scan: dequeue and peek take the oldest entry unconditionally
  always_comb begin
    unique case (cmd_q)
      omq_pkg::CMD_DEQUEUE,
      omq_pkg::CMD_PEEK:     hit = 1'b1;
      omq_pkg::CMD_FIND_OPP: hit = (rd_key != key_q) && (rd_lvl == lvl_q);
      default:               hit = (rd_key == key_q);
    endcase
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    lvl_d     = lvl_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    rkey_d    = rkey_q;
    qcnt_d    = qcnt_q;
    ram_we    = 1'b0;
    ram_waddr = wrap(PW'(head_q) + PW'(count_q));
    ram_wdata = {user_key_i, lvl_in};
    ram_raddr = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = command_i;
          key_d = user_key_i;
          lvl_d = lvl_in;
          idx_d = '0;
          // default result fields, overridden below
          done_d   = 1'b1;
          status_d = omq_pkg::ST_OK;
          found_d  = 1'b0;
          rkey_d   = '0;
          qcnt_d   = omq_pkg::QCNT_W'(count_q);
          unique case (command_i)
            omq_pkg::CMD_ENQUEUE: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = omq_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
                qcnt_d  = omq_pkg::QCNT_W'(count_q + CW'(1));
              end
            end
            omq_pkg::CMD_DEQUEUE,
            omq_pkg::CMD_PEEK: begin
              if (count_q == '0) begin
                status_d = omq_pkg::ST_EMPTY;
              end else begin
                done_d  = 1'b0;
                state_d = S_LOOK;   // oldest entry read is under way
              end
            end
            omq_pkg::CMD_CONTAINS,
            omq_pkg::CMD_FIND_OPP,
            omq_pkg::CMD_REMOVE: begin
              if (count_q == '0) begin
                status_d = omq_pkg::ST_NOMATCH;
              end else begin
                done_d  = 1'b0;
                state_d = S_LOOK;
              end
            end
            default: ;  // unused codes: no-op, ok
          endcase
        end
      end

      S_LOOK: begin
        if (hit) begin
          if (cmd_q == omq_pkg::CMD_REMOVE && !last1) begin
            // fetch the entry behind the match, then move entries down
            ram_raddr = wrap(PW'(head_q) + pos1);
            state_d   = S_SHIFT;
          end else begin
            done_d   = 1'b1;
            status_d = omq_pkg::ST_OK;
            found_d  = 1'b1;
            rkey_d   = rd_key;
            qcnt_d   = omq_pkg::QCNT_W'(count_q);
            state_d  = S_IDLE;
            if (cmd_q == omq_pkg::CMD_DEQUEUE) begin
              head_d  = wrap(PW'(head_q) + PW'(1));
              count_d = count_dec;
              qcnt_d  = omq_pkg::QCNT_W'(count_dec);
            end else if (cmd_q == omq_pkg::CMD_REMOVE) begin
              // match was the youngest entry: nothing to move
              count_d = count_dec;
              qcnt_d  = omq_pkg::QCNT_W'(count_dec);
            end
          end
        end else if (last1) begin
          done_d   = 1'b1;
          status_d = omq_pkg::ST_NOMATCH;
          found_d  = 1'b0;
          rkey_d   = '0;
          qcnt_d   = omq_pkg::QCNT_W'(count_q);
          state_d  = S_IDLE;
        end else begin
          idx_d     = pos1[AW-1:0];
          ram_raddr = wrap(PW'(head_q) + pos1);
        end
      end

      S_SHIFT: begin
        // read data is entry idx+1; write it into slot idx
        ram_we    = 1'b1;
        ram_waddr = wrap(PW'(head_q) + {1'b0, idx_q});
        ram_wdata = ram_rdata;
        idx_d     = pos1[AW-1:0];
        if (last2) begin
          done_d   = 1'b1;
          status_d = omq_pkg::ST_OK;
          found_d  = 1'b1;
          rkey_d   = key_q;
          count_d  = count_dec;
          qcnt_d   = omq_pkg::QCNT_W'(count_dec);
          state_d  = S_IDLE;
        end else begin
          ram_raddr = wrap(PW'(head_q) + pos2);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    lvl_q    <= lvl_d;
    status_q <= status_d;
    found_q  <= found_d;
    rkey_q   <= rkey_d;
    qcnt_q   <= qcnt_d;
  end

  omq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign result_key_o  = rkey_q;
  assign queue_count_o = qcnt_q;

  // fill never exceeds capacity
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill above capacity");

  // results only issue as the FSM returns to idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result issued while still busy");

  // a found result always carries ok status
  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && found_q) |-> status_q == omq_pkg::ST_OK)
    else $error("found result with error status");

  // enqueue answers in the next cycle
  a_enq_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == omq_pkg::CMD_ENQUEUE) |=> done_q)
    else $error("enqueue result late");

  // compaction writes stay inside the occupied range
  a_shift_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> pos2 <= PW'(count_q))
    else $error("compaction beyond fill");

endmodule

// ===== hdl/omq_ram.sv =====
`timescale 1ns / 1ps
// omq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module omq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/ordered_match_queue_test.sv =====
`timescale 1ns / 1ps
// ordered_match_queue_test: self-checking bench for the ordered match queue.
// Depends on omq_pkg and ordered_match_queue; drives a directed table, then random commands.
module ordered_match_queue_test;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned RANDOM_CMDS = 1350;
  // Quiet cycles allowed before the run is declared hung. The slowest transfer is the
  // longest send gap plus a full-depth compacting removal, far below this.
  localparam int unsigned QUIET_LIMIT = 600;
  // Cycles to keep watching after the last result, for stray strobes.
  localparam int unsigned DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

  // Unused command codes: the block must leave its state alone and answer OK.
  localparam logic [omq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [omq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [omq_pkg::KEY_W-1:0] key;
    logic [omq_pkg::LVL_W-1:0] lvl;
  } entry_t;

  typedef struct packed {
    logic [omq_pkg::STAT_W-1:0] status;
    logic                       found;
    logic [omq_pkg::KEY_W-1:0]  key_out;
    logic [omq_pkg::QCNT_W-1:0] fill;
  } outcome_t;

  // One directed row. Rows with reps > 1 repeat the command with the key stepping by one.
  // Where typed is set, want holds the hand-written result; otherwise the predictor decides.
  typedef struct packed {
    logic [omq_pkg::CMD_W-1:0] cmd;
    logic [omq_pkg::KEY_W-1:0] key;
    logic [omq_pkg::LVL_W-1:0] lvl;
    logic [4:0]                reps;
    logic                      typed;
    outcome_t                  want;
  } step_row_t;

  localparam int unsigned NUM_ROWS = 23;

  step_row_t directed_rows [0:NUM_ROWS-1] = '{
    // empty queue: every lookup reports empty or no match, spare codes do nothing
    '{omq_pkg::CMD_DEQUEUE,  32'h0000_0000, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_EMPTY,   1'b0, 32'h0, 5'd0}},
    '{omq_pkg::CMD_PEEK,     32'h1234_5678, 8'h5A, 5'd1, 1'b1,
      '{omq_pkg::ST_EMPTY,   1'b0, 32'h0, 5'd0}},
    '{omq_pkg::CMD_CONTAINS, 32'h0000_0000, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_NOMATCH, 1'b0, 32'h0, 5'd0}},
    '{omq_pkg::CMD_FIND_OPP, 32'h0000_0000, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_NOMATCH, 1'b0, 32'h0, 5'd0}},
    '{omq_pkg::CMD_REMOVE,   32'hFFFF_FFFF, 8'hFF, 5'd1, 1'b1,
      '{omq_pkg::ST_NOMATCH, 1'b0, 32'h0, 5'd0}},
    '{CMD_SPARE_LO,          32'hFFFF_FFFF, 8'hFF, 5'd1, 1'b1,
      '{omq_pkg::ST_OK,      1'b0, 32'h0, 5'd0}},
    '{CMD_SPARE_HI,          32'h0000_0000, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_OK,      1'b0, 32'h0, 5'd0}},
    // extreme keys and levels, with a duplicate key
    '{omq_pkg::CMD_ENQUEUE,  32'hFFFF_FFFF, 8'hFF, 5'd1, 1'b1,
      '{omq_pkg::ST_OK,      1'b0, 32'h0, 5'd1}},
    '{omq_pkg::CMD_ENQUEUE,  32'h0000_0000, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_OK,      1'b0, 32'h0, 5'd2}},
    '{omq_pkg::CMD_ENQUEUE,  32'hFFFF_FFFF, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_OK,      1'b0, 32'h0, 5'd3}},
    '{omq_pkg::CMD_PEEK,     32'h0000_0000, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_OK,      1'b1, 32'hFFFF_FFFF, 5'd3}},
    '{omq_pkg::CMD_CONTAINS, 32'h0000_0000, 8'h00, 5'd1, 1'b1,
      '{omq_pkg::ST_OK,      1'b1, 32'h0, 5'd3}},
    // opponent search: skip own key, match on level, none when only own key has it
    '{omq_pkg::CMD_FIND_OPP, 32'hFFFF_FFFF, 8'h00, 5'd1, 1'b0, '0},
    '{omq_pkg::CMD_FIND_OPP, 32'h0000_0000, 8'hFF, 5'd1, 1'b0, '0},
    '{omq_pkg::CMD_FIND_OPP, 32'hFFFF_FFFF, 8'hFF, 5'd1, 1'b0, '0},
    // remove hits the oldest of two duplicates
    '{omq_pkg::CMD_REMOVE,   32'hFFFF_FFFF, 8'h00, 5'd1, 1'b0, '0},
    '{omq_pkg::CMD_DEQUEUE,  32'h0000_0000, 8'h00, 5'd1, 1'b0, '0},
    // fill to the brim, then overflow
    '{omq_pkg::CMD_ENQUEUE,  32'hA5A5_0000, 8'h55, 5'd15, 1'b0, '0},
    '{omq_pkg::CMD_ENQUEUE,  32'h5A5A_5A5A, 8'hAA, 5'd1, 1'b1,
      '{omq_pkg::ST_FULL,    1'b0, 32'h0, 5'd16}},
    // compaction from the middle and from the youngest slot
    '{omq_pkg::CMD_REMOVE,   32'hA5A5_0007, 8'h00, 5'd1, 1'b0, '0},
    '{omq_pkg::CMD_REMOVE,   32'hA5A5_000E, 8'h00, 5'd1, 1'b0, '0},
    '{CMD_SPARE_LO,          32'h5A5A_5A5A, 8'hAA, 5'd1, 1'b0, '0},
    '{omq_pkg::CMD_CONTAINS, 32'hA5A5_0007, 8'h00, 5'd1, 1'b0, '0}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [omq_pkg::CMD_W-1:0]  command_i = omq_pkg::CMD_ENQUEUE;
  logic [omq_pkg::KEY_W-1:0]  user_key_i = '0;
  logic [omq_pkg::LVL_W-1:0]  level_i = '0;
  logic                       done_o;
  logic [omq_pkg::STAT_W-1:0] status_o;
  logic                       found_o;
  logic [omq_pkg::KEY_W-1:0]  result_key_o;
  logic [omq_pkg::QCNT_W-1:0] queue_count_o;

  entry_t   held_entries[$];      // predicted queue contents, oldest first
  outcome_t awaited_outcomes[$];  // results owed by the block, oldest first
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  ordered_match_queue #(
    .DEPTH      (QUEUE_DEPTH),
    .LEVEL_BITS (omq_pkg::LVL_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .user_key_i    (user_key_i),
    .level_i       (level_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .result_key_o  (result_key_o),
    .queue_count_o (queue_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor: applies one command to the modeled queue and returns the result it owes.
  function automatic outcome_t apply_queue_op(logic [omq_pkg::CMD_W-1:0] cmd,
                                              logic [omq_pkg::KEY_W-1:0] key,
                                              logic [omq_pkg::LVL_W-1:0] lvl);
    outcome_t res;
    int       hit;
    res = '{omq_pkg::ST_OK, 1'b0, '0, '0};
    hit = -1;
    case (cmd)
      omq_pkg::CMD_ENQUEUE: begin
        if (held_entries.size() >= QUEUE_DEPTH) res.status = omq_pkg::ST_FULL;
        else held_entries.push_back('{key, lvl});
      end
      omq_pkg::CMD_DEQUEUE, omq_pkg::CMD_PEEK: begin
        if (held_entries.size() == 0) begin
          res.status = omq_pkg::ST_EMPTY;
        end else begin
          res.found = 1'b1;
          res.key_out = held_entries[0].key;
          if (cmd == omq_pkg::CMD_DEQUEUE) void'(held_entries.pop_front());
        end
      end
      omq_pkg::CMD_CONTAINS, omq_pkg::CMD_REMOVE: begin
        foreach (held_entries[i])
          if (hit < 0 && held_entries[i].key == key) hit = i;
        if (hit < 0) begin
          res.status = omq_pkg::ST_NOMATCH;
        end else begin
          res.found = 1'b1;
          res.key_out = key;
          if (cmd == omq_pkg::CMD_REMOVE) held_entries.delete(hit);
        end
      end
      omq_pkg::CMD_FIND_OPP: begin
        // oldest entry on the same level that belongs to someone else
        foreach (held_entries[i])
          if (hit < 0 && held_entries[i].key != key && held_entries[i].lvl == lvl) hit = i;
        if (hit < 0) begin
          res.status = omq_pkg::ST_NOMATCH;
        end else begin
          res.found = 1'b1;
          res.key_out = held_entries[hit].key;
        end
      end
      default: ;
    endcase
    res.fill = omq_pkg::QCNT_W'(held_entries.size());
    return res;
  endfunction

  // Waits out the gap, presents the command and returns after the transfer, once busy is low.
  // start is only lowered when a gap follows, so a back-to-back command keeps it high.
  task automatic send_command(input logic [omq_pkg::CMD_W-1:0] cmd,
                              input logic [omq_pkg::KEY_W-1:0] key,
                              input logic [omq_pkg::LVL_W-1:0] lvl, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= cmd;
    user_key_i <= key;
    level_i    <= lvl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [omq_pkg::KEY_W-1:0] want,
                             input logic [omq_pkg::KEY_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Result checker: outputs are sampled at the edge that ends the done_o cycle.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (awaited_outcomes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual status %0d key %h count %0d",
                 $time, status_o, result_key_o, queue_count_o);
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("status", omq_pkg::KEY_W'(want.status), omq_pkg::KEY_W'(status_o));
        check_field("found", omq_pkg::KEY_W'(want.found), omq_pkg::KEY_W'(found_o));
        check_field("result_key", want.key_out, result_key_o);
        check_field("queue_count", omq_pkg::KEY_W'(want.fill),
                    omq_pkg::KEY_W'(queue_count_o));
      end
    end
  end

  // Hang detector: any command or result transfer restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL ordered_match_queue");
      $finish;
    end
  end

  initial begin
    logic [omq_pkg::KEY_W-1:0] key_pool [0:7];
    logic [omq_pkg::CMD_W-1:0] cmd;
    logic [omq_pkg::KEY_W-1:0] key;
    logic [omq_pkg::LVL_W-1:0] lvl;
    outcome_t                  res;
    int unsigned               burst_left;
    int unsigned               phase_left;
    int unsigned               enq_pct;
    int unsigned               gap;
    int unsigned               roll;
    bit                        filling;

    // A small pool of keys makes duplicates, hits and removals common; two are extremes.
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    burst_left = 0;
    phase_left = 0;
    filling = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. Typed rows still run the predictor so its queue stays in step.
    foreach (directed_rows[r]) begin
      for (int unsigned k = 0; k < directed_rows[r].reps; k++) begin
        key = directed_rows[r].key + k;
        send_command(directed_rows[r].cmd, key, directed_rows[r].lvl, $urandom_range(0, 3));
        res = apply_queue_op(directed_rows[r].cmd, key, directed_rows[r].lvl);
        awaited_outcomes.push_back(directed_rows[r].typed ? directed_rows[r].want : res);
      end
    end

    // Random part. The mix swings between filling and draining phases so the fill level
    // sweeps from empty to full; searches often target keys that are actually queued.
    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      if (phase_left == 0) begin
        filling = ~filling;
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      enq_pct = filling ? 50 : 15;

      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
        cmd = omq_pkg::CMD_ENQUEUE;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 22) cmd = omq_pkg::CMD_DEQUEUE;
        else if (roll < 36) cmd = omq_pkg::CMD_PEEK;
        else if (roll < 54) cmd = omq_pkg::CMD_CONTAINS;
        else if (roll < 74) cmd = omq_pkg::CMD_FIND_OPP;
        else if (roll < 97) cmd = omq_pkg::CMD_REMOVE;
        else cmd = roll[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
      end

      roll = $urandom_range(0, 9);
      if (roll < 2) key = $urandom();
      else if (roll < 6 && held_entries.size() > 0)
        key = held_entries[$urandom_range(0, held_entries.size() - 1)].key;
      else key = key_pool[$urandom_range(0, 7)];

      lvl = ($urandom_range(0, 5) == 0) ? omq_pkg::LVL_W'($urandom_range(0, 255))
                                        : omq_pkg::LVL_W'($urandom_range(0, 3));

      // Sender gaps: mostly random, with occasional back-to-back bursts.
      if (burst_left == 0 && $urandom_range(0, 7) == 0) burst_left = $urandom_range(10, 40);
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 15);
      end

      send_command(cmd, key, lvl, gap);
      awaited_outcomes.push_back(apply_queue_op(cmd, key, lvl));
    end

    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS ordered_match_queue");
    end else begin
      $display("FAIL ordered_match_queue");
    end
    $finish;
  end

endmodule
